// ===== rtl/lhs_pkg.sv =====
// package: types, constants and helpers for the latency histogram statistics unit
`default_nettype none
package lhs_pkg;
   localparam int BucketsDefault = 16;
   localparam logic [1:0] OP_NOTE   = 2'd0;
   localparam logic [1:0] OP_REPORT = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] elapsed_ms;
      logic        query_failed;
      logic [31:0] memory_used;
      logic [31:0] reply_length;
      logic [31:0] bytes_sent;
   } req_type;

   typedef struct packed {
      logic [31:0] total_queries;
      logic [31:0] failed_queries;
      logic [31:0] mean_time;
      logic [31:0] mean_memory;
      logic [31:0] mean_reply;
      logic [31:0] mean_bytes;
      logic [31:0] longest_time;
      logic [31:0] shortest_time;
      logic [31:0] pct97_estimate;
      logic [63:0] squares_total;
   } rsp_type;

   // upper limit of bucket i: 32, 64, 125, 250, ... held in 64 bits
   function automatic logic [63:0] bucket_limit(input logic [5:0] i);
      logic [63:0] lim;
      lim = 64'd125;
      if (i == 6'd0) lim = 64'd32;
      else if (i == 6'd1) lim = 64'd64;
      else lim = 64'd125 << (i - 6'd2);
      return lim;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/lhs_ram.sv =====
// generic simple dual-port ram (one write port, one read port) with registered read
`default_nettype none
module lhs_ram #(
   parameter int Width = 32,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/latency_histogram_stats_unit.sv =====
// top level: latency statistics with a log-spaced histogram in a ram
`default_nettype none
// Latency histogram statistics. A note beat keeps the input stalled after it is
// taken, until its steps are done: read of its bucket from the ram, the add and
// write-back, then the scalar totals (the squared time comes from a registered
// 32x32 multiply). A clear beat, and the pass after reset, sweeps the bucket ram
// one entry a cycle, during which no beat is taken. A report keeps the input
// stalled while a 64-by-32 restoring divider, one quotient bit a cycle, runs four
// times for the means, then the buckets are walked one ram read at a time, each
// read followed by a wait state that adds it to the running sum, held scaled by
// 100 so the percentile target needs no divide, and a last state loads the output
// register. The result sits in that register; the next beat is taken while it
// waits, but a second report holds in its output state until the first is taken.
module latency_histogram_stats_unit import lhs_pkg::*; #(
   parameter int BUCKETS = BucketsDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);
   localparam int AW = $clog2(BUCKETS);
   localparam logic [AW-1:0] LastIdx = AW'(BUCKETS - 1);

   typedef enum logic [3:0] {
      S_CLR, S_IDLE, S_NRD, S_NWR, S_NSQ, S_DIV, S_WALK, S_WAIT, S_OUT
   } state_type;

   state_type state_ff;
   req_type req_ff;
   logic [31:0] cnt_ff, fail_ff, max_ff, min_ff;
   logic [63:0] tsum_ff, sq_ff, msum_ff, rsum_ff, bsum_ff, prod_ff;
   logic [AW-1:0] idx_ff, bidx_ff;
   logic [1:0] dsel_ff;
   logic [6:0] dbit_ff;
   logic [63:0] rem_ff, quo_ff, run_ff;
   logic [31:0] mtime_ff, mmem_ff, mrep_ff, mbyt_ff;
   logic [32:0] pct_ff;
   logic found_ff;
   rsp_type rsp_ff;
   logic rspv_ff;

   logic wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [31:0] wr_data, rd_data;

   lhs_ram #(.Width(32), .Depth(BUCKETS)) u_ram (
      .clock, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
   );

   // bucket index of a time, as a chain of 64-bit compares against the bucket limits
   function automatic logic [AW-1:0] bucket_of(input logic [31:0] t);
      logic [AW-1:0] b;
      b = LastIdx;
      for (int i = BUCKETS - 2; i >= 0; i--)
         if ({32'd0, t} <= bucket_limit(6'(i))) b = AW'(i);
      return b;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rspv_ff;
   assign rsp_data  = rsp_ff;

   assign wr_en   = (state_ff == S_CLR) || (state_ff == S_NWR);
   assign wr_addr = (state_ff == S_CLR) ? idx_ff : bidx_ff;
   assign wr_data = (state_ff == S_CLR) ? 32'd0 : rd_data + 32'd1;
   always_comb begin
      case (state_ff)
         S_IDLE: rd_addr = bucket_of(req_data.elapsed_ms);
         // keep the note's bucket on the read port until the write-back
         S_NRD: rd_addr = bidx_ff;
         default: rd_addr = idx_ff;
      endcase
   end

   logic [63:0] dividend;
   always_comb begin
      case (dsel_ff)
         2'd0: dividend = tsum_ff;
         2'd1: dividend = msum_ff;
         2'd2: dividend = rsum_ff;
         default: dividend = bsum_ff;
      endcase
   end

   // one restoring step
   logic [64:0] trial;
   logic [63:0] rem_sh;
   always_comb begin
      rem_sh = {rem_ff[62:0], dividend[dbit_ff[5:0]]};
      trial = {1'b0, rem_sh} - {33'd0, cnt_ff};
   end

   // percentile target times 100: running sum reaches it when 100*run + 100 > this
   logic [63:0] tgt_num;
   logic [63:0] run_nx;
   logic [63:0] lim;
   assign tgt_num = {32'd0, cnt_ff} * 64'd97 + 64'd50;
   assign run_nx = run_ff + {32'd0, rd_data} * 64'd100;
   assign lim = bucket_limit(6'(idx_ff));

   logic [63:0] q;
   logic [31:0] q_sat;
   always_comb begin
      q = (cnt_ff == 32'd0) ? 64'd0 : {quo_ff[62:0], !trial[64]};
      q_sat = (q[63:32] != 32'd0) ? '1 : q[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; idx_ff <= '0; rspv_ff <= 1'b0;
         cnt_ff <= '0; fail_ff <= '0; max_ff <= '0; min_ff <= '0;
         tsum_ff <= '0; sq_ff <= '0; msum_ff <= '0; rsum_ff <= '0; bsum_ff <= '0;
      end else begin
         if (rspv_ff && !rsp_stall) rspv_ff <= 1'b0;
         case (state_ff)
            S_CLR: begin
               idx_ff <= idx_ff + AW'(1);
               if (idx_ff == LastIdx) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  req_ff <= req_data;
                  bidx_ff <= bucket_of(req_data.elapsed_ms);
                  idx_ff <= '0;
                  case (req_data.opcode)
                     OP_NOTE: state_ff <= S_NRD;
                     OP_REPORT: begin
                        state_ff <= S_DIV; dsel_ff <= 2'd0; dbit_ff <= 7'd63;
                        rem_ff <= '0; quo_ff <= '0;
                     end
                     OP_CLEAR: begin
                        state_ff <= S_CLR;
                        cnt_ff <= '0; fail_ff <= '0; max_ff <= '0; min_ff <= '0;
                        tsum_ff <= '0; sq_ff <= '0; msum_ff <= '0;
                        rsum_ff <= '0; bsum_ff <= '0;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_NRD: begin
               prod_ff <= {32'd0, req_ff.elapsed_ms} * {32'd0, req_ff.elapsed_ms};
               state_ff <= S_NWR;
            end
            S_NWR: state_ff <= S_NSQ;
            S_NSQ: begin
               sq_ff <= sq_ff + prod_ff;
               tsum_ff <= tsum_ff + {32'd0, req_ff.elapsed_ms};
               msum_ff <= msum_ff + {32'd0, req_ff.memory_used};
               rsum_ff <= rsum_ff + {32'd0, req_ff.reply_length};
               bsum_ff <= bsum_ff + {32'd0, req_ff.bytes_sent};
               if (req_ff.elapsed_ms > max_ff) max_ff <= req_ff.elapsed_ms;
               if (cnt_ff == 32'd0 || req_ff.elapsed_ms < min_ff)
                  min_ff <= req_ff.elapsed_ms;
               cnt_ff <= cnt_ff + 32'd1;
               if (req_ff.query_failed) fail_ff <= fail_ff + 32'd1;
               state_ff <= S_IDLE;
            end
            S_DIV: begin
               if (cnt_ff == 32'd0) begin
                  rem_ff <= rem_sh; quo_ff <= '0;
               end else if (!trial[64]) begin
                  rem_ff <= trial[63:0]; quo_ff <= {quo_ff[62:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh; quo_ff <= {quo_ff[62:0], 1'b0};
               end
               dbit_ff <= dbit_ff - 7'd1;
               if (dbit_ff == 7'd0) begin
                  rem_ff <= '0; quo_ff <= '0; dbit_ff <= 7'd63;
                  dsel_ff <= dsel_ff + 2'd1;
                  case (dsel_ff)
                     2'd0: mtime_ff <= q_sat;
                     2'd1: mmem_ff <= q_sat;
                     2'd2: mrep_ff <= q_sat;
                     default: mbyt_ff <= q_sat;
                  endcase
                  if (dsel_ff == 2'd3) begin
                     state_ff <= S_WALK; idx_ff <= '0; run_ff <= '0; found_ff <= 1'b0;
                  end
               end
            end
            S_WALK: state_ff <= S_WAIT;
            S_WAIT: begin
               // rd_data holds bucket idx_ff
               run_ff <= run_nx;
               if (!found_ff && (run_nx + 64'd100) > tgt_num) begin
                  found_ff <= 1'b1;
                  pct_ff <= (lim > {32'd0, max_ff}) ? {1'b0, max_ff} : {1'b0, lim[31:0]};
               end
               if (idx_ff == LastIdx) state_ff <= S_OUT;
               else begin
                  idx_ff <= idx_ff + AW'(1); state_ff <= S_WALK;
               end
            end
            S_OUT: begin
               if (!rspv_ff || !rsp_stall) begin
                  rspv_ff <= 1'b1;
                  rsp_ff.total_queries <= cnt_ff;
                  rsp_ff.failed_queries <= fail_ff;
                  rsp_ff.mean_time <= mtime_ff;
                  rsp_ff.mean_memory <= mmem_ff;
                  rsp_ff.mean_reply <= mrep_ff;
                  rsp_ff.mean_bytes <= mbyt_ff;
                  rsp_ff.longest_time <= max_ff;
                  rsp_ff.shortest_time <= min_ff;
                  rsp_ff.squares_total <= sq_ff;
                  rsp_ff.pct97_estimate <= found_ff ? pct_ff[31:0] : max_ff;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

// ===== rtl/lhs_checker.sv =====
// checker on the ports of the latency histogram statistics unit, with its bind
`default_nettype none
module lhs_checker import lhs_pkg::*; (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data)) else $error("rsp beat dropped");
   a_note_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.opcode == OP_NOTE |=> req_stall)
      else $error("note not interlocked");
   a_minmax: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.shortest_time <= rsp_data.longest_time)
      else $error("min above max");
   a_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.total_queries == 32'd0 |-> rsp_data.mean_time == 32'd0)
      else $error("mean of empty store");
endmodule
bind latency_histogram_stats_unit lhs_checker u_lhs_checker (.*);
`default_nettype wire

// ===== tb/tb_latency_histogram_stats_unit.sv =====
// testbench for the latency histogram statistics unit: directed and random beats checked against a predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_latency_histogram_stats_unit;
   import lhs_pkg::*;

   localparam int NBUCKETS = BucketsDefault;
   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 1500;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   latency_histogram_stats_unit #(.BUCKETS(NBUCKETS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [31:0] n_all, n_fail, t_max, t_min;
   logic [63:0] s_time, s_sq, s_mem, s_rep, s_byt;
   logic [31:0] hist [NBUCKETS];

   rsp_type     pending_reports [$];
   int          errors = 0;
   int          cycles = 0;
   int          hold_cnt = 0;
   bit          burst_mode = 1'b1;
   bit          long_hold = 1'b0;
   bit          hold_done = 1'b0;

   function automatic int bucket_index(logic [31:0] t);
      int          idx;
      logic [63:0] lim;
      if (t <= 32) return 0;
      if (t <= 64) return 1;
      idx = 2;
      lim = 64'd125;
      while (idx < NBUCKETS - 1 && {32'd0, t} > lim) begin
         idx++;
         lim = lim << 1;
      end
      return idx;
   endfunction

   function automatic logic [31:0] mean_val(logic [63:0] sum);
      logic [63:0] q;
      if (n_all == 0) return 32'd0;
      q = sum / {32'd0, n_all};
      return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
   endfunction

   function automatic logic [31:0] pct97_val();
      logic [63:0] target, run, lim;
      target = ({32'd0, n_all} * 64'd97 + 64'd50) / 64'd100;
      run = 0;
      lim = 64'd32;
      for (int i = 0; i < NBUCKETS; i++) begin
         run += {32'd0, hist[i]};
         if (run >= target) return (lim > {32'd0, t_max}) ? t_max : lim[31:0];
         lim = (lim == 64'd64) ? 64'd125 : (lim << 1);
      end
      return t_max;
   endfunction

   function automatic void clear_stats();
      n_all = 0; n_fail = 0; t_max = 0; t_min = 0;
      s_time = 0; s_sq = 0; s_mem = 0; s_rep = 0; s_byt = 0;
      for (int i = 0; i < NBUCKETS; i++) hist[i] = 0;
   endfunction

   function automatic void predict_beat(req_type r);
      rsp_type e;
      case (r.opcode)
         OP_NOTE: begin
            s_time += {32'd0, r.elapsed_ms};
            s_sq += {32'd0, r.elapsed_ms} * {32'd0, r.elapsed_ms};
            s_mem += {32'd0, r.memory_used};
            s_rep += {32'd0, r.reply_length};
            s_byt += {32'd0, r.bytes_sent};
            if (r.elapsed_ms > t_max) t_max = r.elapsed_ms;
            if (n_all == 0 || r.elapsed_ms < t_min) t_min = r.elapsed_ms;
            hist[bucket_index(r.elapsed_ms)] += 1;
            n_all += 1;
            if (r.query_failed) n_fail += 1;
         end
         OP_REPORT: begin
            e.total_queries = n_all;
            e.failed_queries = n_fail;
            e.mean_time = mean_val(s_time);
            e.mean_memory = mean_val(s_mem);
            e.mean_reply = mean_val(s_rep);
            e.mean_bytes = mean_val(s_byt);
            e.longest_time = t_max;
            e.shortest_time = t_min;
            e.pct97_estimate = pct97_val();
            e.squares_total = s_sq;
            pending_reports.push_back(e);
         end
         OP_CLEAR: clear_stats();
         default: ;
      endcase
   endfunction

   // drive one beat and hold it until accepted
   task automatic send_beat(req_type r);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (req_stall);
      predict_beat(r);
      if (burst_mode && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_type make_beat(logic [1:0] op, logic [31:0] t, logic f,
                                         logic [31:0] m, logic [31:0] rl,
                                         logic [31:0] b);
      req_type r;
      r.opcode = op; r.elapsed_ms = t; r.query_failed = f;
      r.memory_used = m; r.reply_length = rl; r.bytes_sent = b;
      return r;
   endfunction

   function automatic logic [31:0] rand_time();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 3) return $urandom_range(0, 70);
      if (sel < 6) return $urandom_range(0, 5000);
      if (sel < 8) return $urandom >> $urandom_range(0, 31);
      return $urandom;
   endfunction

   function automatic req_type rand_note();
      return make_beat(OP_NOTE, rand_time(), 1'($urandom_range(0, 1)), $urandom, $urandom,
                       $urandom);
   endfunction

   task automatic wait_drained();
      drop_valid();
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic test_empty_and_extremes();
      send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      send_beat(make_beat(2'd3, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1, 1));
      send_beat(make_beat(OP_NOTE, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                          32'hFFFF_FFFF));
      send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      send_beat(make_beat(OP_NOTE, 0, 0, 0, 0, 0));
      send_beat(make_beat(OP_NOTE, 32, 0, 5, 6, 7));
      send_beat(make_beat(OP_NOTE, 33, 1, 5, 6, 7));
      send_beat(make_beat(OP_NOTE, 64, 0, 5, 6, 7));
      send_beat(make_beat(OP_NOTE, 65, 0, 5, 6, 7));
      send_beat(make_beat(OP_NOTE, 125, 1, 5, 6, 7));
      send_beat(make_beat(OP_NOTE, 126, 0, 5, 6, 7));
      send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      send_beat(make_beat(OP_CLEAR, 0, 0, 0, 0, 0));
      send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      // single sample: percentile capped at max
      send_beat(make_beat(OP_NOTE, 10, 0, 1, 2, 3));
      send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_random_mix(int n_beats);
      int  roll;
      for (int i = 0; i < n_beats; i++) begin
         roll = $urandom_range(0, 99);
         if (roll < 75) send_beat(rand_note());
         else if (roll < 93) send_beat(make_beat(OP_REPORT, $urandom,
                                                 1'($urandom_range(0, 1)),
                                                 $urandom, $urandom, $urandom));
         else if (roll < 97) send_beat(make_beat(OP_CLEAR, $urandom, 0, $urandom, 0, 0));
         else send_beat(make_beat(2'd3, $urandom, 1, $urandom, $urandom, $urandom));
      end
      wait_drained();
   endtask

   task automatic test_back_pressure();
      burst_mode = 1'b0;
      long_hold = 1'b1;
      for (int i = 0; i < 30; i++) begin
         send_beat(rand_note());
         send_beat(make_beat(OP_REPORT, 0, 0, 0, 0, 0));
      end
      burst_mode = 1'b1;
      wait_drained();
   endtask

   // receiver stall pattern, with one long hold-off on request
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (long_hold && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_cnt <= hold_cnt + 1;
         if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else if (cycles % 400 < 120) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 2) == 0);
   end

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected report beat %h", $realtime, rsp_data);
            errors++;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_data.total_queries !== e.total_queries) begin
               $display("%0t: total_queries exp %h got %h", $realtime, e.total_queries,
                        rsp_data.total_queries); errors++; end
            if (rsp_data.failed_queries !== e.failed_queries) begin
               $display("%0t: failed_queries exp %h got %h", $realtime, e.failed_queries,
                        rsp_data.failed_queries); errors++; end
            if (rsp_data.mean_time !== e.mean_time) begin
               $display("%0t: mean_time exp %h got %h", $realtime, e.mean_time,
                        rsp_data.mean_time); errors++; end
            if (rsp_data.mean_memory !== e.mean_memory) begin
               $display("%0t: mean_memory exp %h got %h", $realtime, e.mean_memory,
                        rsp_data.mean_memory); errors++; end
            if (rsp_data.mean_reply !== e.mean_reply) begin
               $display("%0t: mean_reply exp %h got %h", $realtime, e.mean_reply,
                        rsp_data.mean_reply); errors++; end
            if (rsp_data.mean_bytes !== e.mean_bytes) begin
               $display("%0t: mean_bytes exp %h got %h", $realtime, e.mean_bytes,
                        rsp_data.mean_bytes); errors++; end
            if (rsp_data.longest_time !== e.longest_time) begin
               $display("%0t: longest_time exp %h got %h", $realtime, e.longest_time,
                        rsp_data.longest_time); errors++; end
            if (rsp_data.shortest_time !== e.shortest_time) begin
               $display("%0t: shortest_time exp %h got %h", $realtime, e.shortest_time,
                        rsp_data.shortest_time); errors++; end
            if (rsp_data.pct97_estimate !== e.pct97_estimate) begin
               $display("%0t: pct97_estimate exp %h got %h", $realtime, e.pct97_estimate,
                        rsp_data.pct97_estimate); errors++; end
            if (rsp_data.squares_total !== e.squares_total) begin
               $display("%0t: squares_total exp %h got %h", $realtime, e.squares_total,
                        rsp_data.squares_total); errors++; end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clear_stats();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_back_pressure();
      test_random_mix(340);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_reports.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
